### design/dwarf_eh_pkg.sv
// types, codes and form decode shared by the dwarf exception-header pointer decoder
package dwarf_eh_pkg;

  localparam logic [7:0] ENC_OMIT    = 8'hff;
  localparam logic [7:0] ENC_ALIGNED = 8'h50;
  localparam logic [7:0] APP_MASK    = 8'h70;
  localparam logic [7:0] APP_PCREL   = 8'h10;

  localparam logic [3:0] FORM_ABSPTR  = 4'h0;
  localparam logic [3:0] FORM_ULEB128 = 4'h1;
  localparam logic [3:0] FORM_UDATA2  = 4'h2;
  localparam logic [3:0] FORM_UDATA4  = 4'h3;
  localparam logic [3:0] FORM_UDATA8  = 4'h4;
  localparam logic [3:0] FORM_SIGNED  = 4'h8;
  localparam logic [3:0] FORM_SLEB128 = 4'h9;
  localparam logic [3:0] FORM_SDATA2  = 4'ha;
  localparam logic [3:0] FORM_SDATA4  = 4'hb;
  localparam logic [3:0] FORM_SDATA8  = 4'hc;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_OMITTED     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [7:0]  encoding;
    logic [63:0] field_address;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  bytes_used;
    logic [1:0]  status;
    logic        needs_indirect;
  } rsp_t;

  typedef struct packed {
    logic       supported;
    logic       is_leb;
    logic       is_sleb;
    logic       is_signed;
    logic [3:0] size;
  } form_t;

  function automatic form_t form_decode(input logic [7:0] enc);
    form_t f;
    f = '0;
    unique case (enc[3:0])
      FORM_ABSPTR, FORM_UDATA8, FORM_SIGNED: begin
        f.supported = 1'b1;
        f.size      = 4'd8;
      end
      FORM_ULEB128: begin
        f.supported = 1'b1;
        f.is_leb    = 1'b1;
      end
      FORM_SLEB128: begin
        f.supported = 1'b1;
        f.is_leb    = 1'b1;
        f.is_sleb   = 1'b1;
      end
      FORM_UDATA2: begin
        f.supported = 1'b1;
        f.size      = 4'd2;
      end
      FORM_UDATA4: begin
        f.supported = 1'b1;
        f.size      = 4'd4;
      end
      FORM_SDATA2: begin
        f.supported = 1'b1;
        f.is_signed = 1'b1;
        f.size      = 4'd2;
      end
      FORM_SDATA4: begin
        f.supported = 1'b1;
        f.is_signed = 1'b1;
        f.size      = 4'd4;
      end
      FORM_SDATA8: begin
        f.supported = 1'b1;
        f.is_signed = 1'b1;
        f.size      = 4'd8;
      end
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

### design/dwarf_eh_pointer_decoder.sv
// dwarf exception-header pointer decoder: one stream byte per cycle, one result per value
//
// usage
//   the request channel (req_valid, req_ready, req) carries one stream byte a cycle;
//   req.first marks a value's first byte and brings its encoding and address
//   the response channel (rsp_valid, rsp_ready, rsp) gives value, bytes used,
//   status and the indirect flag once the value's last byte has been taken
//   response timing: the response is registered and shows in the cycle after the request
//   that completes the value; omitted, aligned and unsupported encodings answer
//   in the cycle after their first request
//   throughput: one request per cycle unless a response is stalled, fixed by the single
//   byte-accumulate and pc-relative add path between the state and the response register
//   a request with first low and no value in progress is taken and dropped
//   a first request during a value abandons the old one silently
//   when the receiver stalls with a response pending, req_ready falls and
//   the byte stream waits; it rises in the cycle the response is taken
//   reset (rst, synchronous) clears rsp_valid and leaves the decoder idle
module dwarf_eh_pointer_decoder import dwarf_eh_pkg::*; #(
  parameter int MAX_LEB_BYTES = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [63:0] accumulator;
  logic [6:0]  shift_count;
  logic [3:0]  byte_count;
  logic [7:0]  held_encoding;
  logic [63:0] start_address;
  logic        busy;

  logic [63:0] accumulator_next;
  logic [6:0]  shift_count_next;
  logic [3:0]  byte_count_next;
  logic        busy_next;
  logic        emit;
  rsp_t        rsp_next;

  logic [63:0] cur_acc;
  logic [6:0]  cur_shift;
  logic [3:0]  cur_cnt;
  logic [7:0]  cur_enc;
  logic [63:0] cur_addr;
  logic        active;
  logic        immediate;
  form_t       fd;
  logic [63:0] ins;
  logic [63:0] acc_or;
  logic        done;
  logic        sign_bit;

  logic accept;
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  always_comb begin
    cur_acc   = req.first ? 64'd0 : accumulator;
    cur_shift = req.first ? 7'd0 : shift_count;
    cur_cnt   = req.first ? 4'd0 : byte_count;
    cur_enc   = req.first ? req.encoding : held_encoding;
    cur_addr  = req.first ? req.field_address : start_address;
    fd        = form_decode(cur_enc);

    immediate = req.first && (req.encoding == ENC_OMIT || req.encoding == ENC_ALIGNED
                              || !fd.supported);
    active    = req.first ? !immediate : busy;

    ins              = fd.is_leb ? {57'd0, req.data_byte[6:0]} : {56'd0, req.data_byte};
    acc_or           = cur_acc | ((cur_shift < 7'd64) ? (ins << cur_shift[5:0]) : 64'd0);
    shift_count_next = cur_shift + (fd.is_leb ? 7'd7 : 7'd8);
    byte_count_next  = cur_cnt + 4'd1;
    accumulator_next = acc_or;
    sign_bit         = 1'b0;

    if (fd.is_leb) begin
      done = !req.data_byte[7] || (byte_count_next >= 4'(MAX_LEB_BYTES));
      if (done && fd.is_sleb && shift_count_next < 7'd64 && req.data_byte[6]) begin
        accumulator_next = acc_or | ({64{1'b1}} << shift_count_next[5:0]);
      end
    end else begin
      done = byte_count_next >= fd.size;
      case (fd.size)
        4'd2:    sign_bit = acc_or[15];
        4'd4:    sign_bit = acc_or[31];
        default: sign_bit = 1'b0;
      endcase
      if (done && fd.is_signed && sign_bit) begin
        case (fd.size)
          4'd2:    accumulator_next = acc_or | {{48{1'b1}}, 16'd0};
          4'd4:    accumulator_next = acc_or | {{32{1'b1}}, 32'd0};
          default: accumulator_next = acc_or;
        endcase
      end
    end

    busy_next = active && !done;
    emit      = immediate || (active && done);

    rsp_next = '0;
    if (immediate) begin
      rsp_next.status = (req.encoding == ENC_OMIT) ? ST_OMITTED : ST_UNSUPPORTED;
    end else begin
      rsp_next.status     = ST_OK;
      rsp_next.bytes_used = byte_count_next;
      rsp_next.value      = accumulator_next;
      if (accumulator_next != 64'd0) begin
        if ((cur_enc & APP_MASK) == APP_PCREL) begin
          rsp_next.value = accumulator_next + cur_addr;
        end
        rsp_next.needs_indirect = cur_enc[7];
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      accumulator <= '0;
      shift_count <= '0;
      byte_count  <= '0;
    end else if (accept) begin
      busy <= busy_next;
      if (req.first || busy) begin
        accumulator <= accumulator_next;
        shift_count <= shift_count_next;
        byte_count  <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.first) begin
      held_encoding <= req.encoding;
      start_address <= req.field_address;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      rsp <= rsp_next;
    end
  end

endmodule
